// ----- rtl/dst_pkg.sv -----
// Types and constants shared by the source tokenizer.
`timescale 1ns / 1ps

package dst_pkg;

    // One source byte beat.
    typedef struct packed {
        logic [7:0] source_byte;
        logic       is_last;
    } src_beat_t;

    // One token beat.
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_token;
    } tok_beat_t;

    // Token kinds.
    localparam logic [3:0] KIND_LET    = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_LPAREN = 4'd2;
    localparam logic [3:0] KIND_RPAREN = 4'd3;
    localparam logic [3:0] KIND_COMMA  = 4'd4;
    localparam logic [3:0] KIND_PLUS   = 4'd5;
    localparam logic [3:0] KIND_STAR   = 4'd6;
    localparam logic [3:0] KIND_MINUS  = 4'd7;
    localparam logic [3:0] KIND_EQUALS = 4'd8;
    localparam logic [3:0] KIND_NUMBER = 4'd9;
    localparam logic [3:0] KIND_AT     = 4'd10;
    localparam logic [3:0] KIND_TILE   = 4'd11;
    localparam logic [3:0] KIND_END    = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_DOTPEND,
        MODE_FRAC,
        MODE_LEADDOT,
        MODE_DROP
    } lex_mode_t;

    // Keyword prefix tracker.
    typedef logic [2:0] kw_prog_t;
    localparam kw_prog_t KW_NONE = 3'd0;
    localparam kw_prog_t KW_L    = 3'd1;
    localparam kw_prog_t KW_LE   = 3'd2;
    localparam kw_prog_t KW_LET  = 3'd3;
    localparam kw_prog_t KW_T    = 3'd4;
    localparam kw_prog_t KW_TI   = 3'd5;
    localparam kw_prog_t KW_TIL  = 3'd6;
    localparam kw_prog_t KW_TILE = 3'd7;

    // Characters.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    // Advance the let/tile prefix tracker by one identifier character.
    function automatic kw_prog_t kw_next(input kw_prog_t kp, input logic [7:0] b);
        kw_prog_t r;
        r = KW_NONE;
        if (kp == KW_L && b == CH_LC_E) r = KW_LE;
        if (kp == KW_LE && b == CH_LC_T) r = KW_LET;
        if (kp == KW_T && b == CH_LC_I) r = KW_TI;
        if (kp == KW_TI && b == CH_LC_L) r = KW_TIL;
        if (kp == KW_TIL && b == CH_LC_E) r = KW_TILE;
        return r;
    endfunction

endpackage

// ----- rtl/dsl_source_tokenizer.sv -----
// Streaming maximal-munch tokenizer: source bytes in, tokens out.
`timescale 1ns / 1ps

//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------------------------------------
//  src     | in        | src_valid/src_stall  | source_byte, is_last
//  tok     | out       | tok_valid/tok_stall  | token_kind, start_line, start_column,
//          |           |                      | token_length, last_token
//
//  One source byte is taken per cycle while src_stall is low. A byte is held in the input
//  register, then a single pass of decode logic updates the scanner and
//  pushes 0 to 3 tokens into an 8-entry result queue.
//  Tokens leave the queue at one per cycle while tok_stall is low, so bytes that each
//  yield at most one token stream at full rate; the queue absorbs multi-token bursts.
//  src_stall rises while the held byte waits for 3 free queue entries.
//  After reset, and after every byte marked last, the scanner is at line 1,
//  column 1 with no pending token. No clearing pass is needed.
module dsl_source_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  dst_pkg::src_beat_t src_beat,
    output logic               tok_valid,
    input  logic               tok_stall,
    output dst_pkg::tok_beat_t tok_beat
);
    import dst_pkg::*;

    localparam int PW      = POSITION_BITS;
    localparam int Q_DEPTH = 8;
    localparam int MAX_RES = 3;
    localparam int QA_W    = $clog2(Q_DEPTH);

    // Clip a position to the 16-bit output field.
    function automatic logic [15:0] clip16(input logic [PW-1:0] v);
        logic [PW+15:0] ext;
        ext = {16'b0, v};
        return (ext[PW+15:16] != '0) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic logic [PW-1:0] sat_pos(input logic [PW-1:0] v);
        return (v == '1) ? v : v + PW'(1);
    endfunction

    function automatic logic [3:0] pend_kind(input lex_mode_t m, input kw_prog_t kp);
        logic [3:0] k;
        k = KIND_NUMBER;
        if (m == MODE_IDENT)
            k = (kp == KW_LET) ? KIND_LET : ((kp == KW_TILE) ? KIND_TILE : KIND_IDENT);
        return k;
    endfunction

    function automatic tok_beat_t mk_tok(input logic [3:0] kind, input logic [PW-1:0] line,
                                        input logic [PW-1:0] col, input logic [15:0] len,
                                        input logic last);
        tok_beat_t t;
        t.token_kind   = kind;
        t.start_line   = clip16(line);
        t.start_column = clip16(col);
        t.token_length = len;
        t.last_token   = last;
        return t;
    endfunction

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic      src_vld_reg, src_vld_next;
    src_beat_t src_reg;
    logic      src_take;
    logic      proc_go;

    // Result queue control
    tok_beat_t         q_reg [Q_DEPTH];
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W:0]     q_cnt_reg, q_cnt_next;
    logic              q_pop;

    assign proc_go   = src_vld_reg && (q_cnt_reg <= (QA_W+1)'(Q_DEPTH - MAX_RES));
    assign src_stall = src_vld_reg && !proc_go;
    assign src_take  = src_valid && !src_stall;

    always_comb
    begin
        src_vld_next = src_vld_reg;
        if (src_take)
            src_vld_next = 1'b1;
        else if (proc_go)
            src_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            src_vld_reg <= 1'b0;
        else
            src_vld_reg <= src_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
            src_reg <= src_beat;
    end

    // ---------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------
    logic [7:0] b;
    logic       is_alpha, is_digit, is_dot, is_space, is_nl, is_punct, is_unknown;
    logic [3:0] punct_kind;

    assign b        = src_reg.source_byte;
    assign is_alpha = (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) ||
                      (b == CH_UNDER);
    assign is_digit = (b >= CH_0 && b <= CH_9);
    assign is_dot   = (b == CH_DOT);
    assign is_nl    = (b == CH_LF);
    assign is_space = (b == CH_SPACE) || (b == CH_CR) || (b == CH_TAB) || is_nl;

    always_comb
    begin
        is_punct   = 1'b1;
        punct_kind = KIND_ERROR;
        case (b)
            CH_LPAREN: punct_kind = KIND_LPAREN;
            CH_RPAREN: punct_kind = KIND_RPAREN;
            CH_COMMA:  punct_kind = KIND_COMMA;
            CH_PLUS:   punct_kind = KIND_PLUS;
            CH_STAR:   punct_kind = KIND_STAR;
            CH_MINUS:  punct_kind = KIND_MINUS;
            CH_EQUALS: punct_kind = KIND_EQUALS;
            CH_AT:     punct_kind = KIND_AT;
            default:   is_punct   = 1'b0;
        endcase
    end

    assign is_unknown = !(is_punct || is_space || is_alpha || is_digit || is_dot);

    // ---------------------------------------------------------------
    // Scanner state
    // ---------------------------------------------------------------
    lex_mode_t       mode_reg, mode_next, mode_h;
    logic [PW-1:0]   line_reg, line_next, line_n;
    logic [PW-1:0]   col_reg, col_next, col_n;
    logic [PW-1:0]   tsl_reg, tsl_next, tsl_h;
    logic [PW-1:0]   tsc_reg, tsc_next, tsc_h;
    logic [PW-1:0]   dot_reg, dot_next, dot_h;
    logic [15:0]     cnt_reg, cnt_next, cnt_h;
    kw_prog_t        kp_reg, kp_next, kp_h;
    logic            term_pend;   // pending ident/number ends at this byte
    logic            idle_path;   // byte is scanned as a fresh token start
    logic [16:0]     cnt_plus1, cnt_plus2;

    assign cnt_plus1 = {1'b0, cnt_reg} + 17'd1;
    assign cnt_plus2 = {1'b0, cnt_reg} + 17'd2;

    always_comb
    begin
        term_pend = 1'b0;
        case (mode_reg)
            MODE_IDENT: term_pend = !(is_alpha || is_digit);
            MODE_INT:   term_pend = !(is_digit || is_dot);
            MODE_FRAC:  term_pend = !is_digit;
            default:    term_pend = 1'b0;
        endcase
    end

    assign idle_path = (mode_reg == MODE_IDLE) || term_pend;

    // Next state
    always_comb
    begin
        mode_h = mode_reg;
        tsl_h  = tsl_reg;
        tsc_h  = tsc_reg;
        dot_h  = dot_reg;
        cnt_h  = cnt_reg;
        kp_h   = kp_reg;

        if (idle_path)
        begin
            mode_h = MODE_IDLE;
            if (is_alpha || is_digit || is_dot)
            begin
                tsl_h = line_reg;
                tsc_h = col_reg;
                cnt_h = 16'd1;
                if (is_alpha)
                begin
                    mode_h = MODE_IDENT;
                    kp_h   = (b == CH_LC_L) ? KW_L : ((b == CH_LC_T) ? KW_T : KW_NONE);
                end
                else if (is_digit)
                    mode_h = MODE_INT;
                else
                    mode_h = MODE_LEADDOT;
            end
            else if (is_unknown)
                mode_h = MODE_DROP;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    cnt_h = cnt_plus1[16] ? 16'hFFFF : cnt_plus1[15:0];
                    kp_h  = kw_next(kp_reg, b);
                end
                MODE_INT:
                begin
                    if (is_digit)
                        cnt_h = cnt_plus1[16] ? 16'hFFFF : cnt_plus1[15:0];
                    else
                    begin
                        dot_h  = col_reg;
                        mode_h = MODE_DOTPEND;
                    end
                end
                MODE_DOTPEND:
                begin
                    if (is_digit)
                    begin
                        cnt_h  = cnt_plus2[16] ? 16'hFFFF : cnt_plus2[15:0];
                        mode_h = MODE_FRAC;
                    end
                    else
                        mode_h = MODE_DROP;
                end
                MODE_FRAC:
                    cnt_h = cnt_plus1[16] ? 16'hFFFF : cnt_plus1[15:0];
                MODE_LEADDOT:
                begin
                    if (is_digit)
                    begin
                        cnt_h  = 16'd2;
                        mode_h = MODE_FRAC;
                    end
                    else
                        mode_h = MODE_DROP;
                end
                default: mode_h = mode_reg;
            endcase
        end

        line_n = is_nl ? sat_pos(line_reg) : line_reg;
        col_n  = is_nl ? PW'(1) : sat_pos(col_reg);

        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        dot_next  = dot_reg;
        cnt_next  = cnt_reg;
        kp_next   = kp_reg;
        if (proc_go)
        begin
            if (src_reg.is_last)
            begin
                mode_next = MODE_IDLE;
                line_next = PW'(1);
                col_next  = PW'(1);
                tsl_next  = '0;
                tsc_next  = '0;
                dot_next  = '0;
                cnt_next  = '0;
                kp_next   = KW_NONE;
            end
            else
            begin
                mode_next = mode_h;
                line_next = line_n;
                col_next  = col_n;
                tsl_next  = tsl_h;
                tsc_next  = tsc_h;
                dot_next  = dot_h;
                cnt_next  = cnt_h;
                kp_next   = kp_h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= PW'(1);
            col_reg  <= PW'(1);
            tsl_reg  <= '0;
            tsc_reg  <= '0;
            dot_reg  <= '0;
            cnt_reg  <= '0;
            kp_reg   <= KW_NONE;
        end
        else
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            dot_reg  <= dot_next;
            cnt_reg  <= cnt_next;
            kp_reg   <= kp_next;
        end
    end

    // ---------------------------------------------------------------
    // Token outputs of one byte: four candidates in model order,
    // packed into at most three slots.
    // ---------------------------------------------------------------
    logic [3:0]  cand_vld;
    tok_beat_t   cand_tok [4];
    tok_beat_t   slot_tok [MAX_RES];
    logic [1:0]  res_n;

    always_comb
    begin
        cand_vld = '0;
        for (int i = 0; i < 4; i++)
            cand_tok[i] = mk_tok(KIND_END, line_n, col_n, 16'd0, 1'b1);

        // pending token closed by this byte
        cand_vld[0] = term_pend || (mode_reg == MODE_DOTPEND && !is_digit);
        cand_tok[0] = mk_tok(pend_kind(mode_reg, kp_reg), tsl_reg, tsc_reg, cnt_reg, 1'b0);

        // dot without digit, or this byte's own token
        if (mode_reg == MODE_DOTPEND && !is_digit)
        begin
            cand_vld[1] = 1'b1;
            cand_tok[1] = mk_tok(KIND_ERROR, line_reg, dot_reg, 16'd1, 1'b1);
        end
        else if (mode_reg == MODE_LEADDOT && !is_digit)
        begin
            cand_vld[1] = 1'b1;
            cand_tok[1] = mk_tok(KIND_ERROR, tsl_reg, tsc_reg, 16'd1, 1'b1);
        end
        else if (idle_path && is_punct)
        begin
            cand_vld[1] = 1'b1;
            cand_tok[1] = mk_tok(punct_kind, line_reg, col_reg, 16'd1, 1'b0);
        end
        else if (idle_path && is_unknown)
        begin
            cand_vld[1] = 1'b1;
            cand_tok[1] = mk_tok(KIND_ERROR, line_reg, col_reg, 16'd1, 1'b1);
        end

        // flush on the last byte
        if (src_reg.is_last)
        begin
            case (mode_h)
                MODE_IDLE:
                    cand_vld[3] = 1'b1;
                MODE_IDENT, MODE_INT, MODE_FRAC:
                begin
                    cand_vld[2] = 1'b1;
                    cand_vld[3] = 1'b1;
                end
                MODE_DOTPEND:
                begin
                    cand_vld[2] = 1'b1;
                    cand_vld[3] = 1'b1;
                    cand_tok[3] = mk_tok(KIND_ERROR, line_n, dot_h, 16'd1, 1'b1);
                end
                MODE_LEADDOT:
                begin
                    cand_vld[3] = 1'b1;
                    cand_tok[3] = mk_tok(KIND_ERROR, tsl_h, tsc_h, 16'd1, 1'b1);
                end
                default: cand_vld[3] = 1'b0;
            endcase
        end
        cand_tok[2] = mk_tok(pend_kind(mode_h, kp_h), tsl_h, tsc_h, cnt_h, 1'b0);
    end

    always_comb
    begin
        res_n = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
            slot_tok[i] = cand_tok[i];
        for (int i = 0; i < 4; i++)
        begin
            if (cand_vld[i] && res_n != 2'(MAX_RES))
            begin
                slot_tok[res_n] = cand_tok[i];
                res_n = res_n + 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    assign tok_valid = (q_cnt_reg != '0);
    assign tok_beat  = q_reg[rd_ptr_reg];
    assign q_pop     = tok_valid && !tok_stall;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + QA_W'(q_pop);
        wr_ptr_next = wr_ptr_reg + (proc_go ? QA_W'(res_n) : '0);
        q_cnt_next  = q_cnt_reg + (proc_go ? (QA_W+1)'(res_n) : '0) - (QA_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (proc_go && 2'(i) < res_n)
                q_reg[wr_ptr_reg + QA_W'(i)] <= slot_tok[i];
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= (QA_W+1)'(Q_DEPTH))
        else $error("result queue overfilled");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go && src_reg.is_last |=> mode_reg == MODE_IDLE && line_reg == PW'(1) &&
                                        col_reg == PW'(1))
        else $error("scanner not back at start after last byte");

    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go && src_reg.is_last && mode_reg != MODE_DROP |-> res_n != 2'd0)
        else $error("last byte produced no closing token");

    a_closing_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_beat.last_token |->
            tok_beat.token_kind == KIND_END || tok_beat.token_kind == KIND_ERROR)
        else $error("closing beat is neither end nor error");

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the source tokenizer: token prediction and beat-level compare.
`timescale 1ns / 1ps

module tb;

    import dst_pkg::*;

    localparam int          POS_BITS     = 16;
    localparam int unsigned POS_LIMIT    = 32'((64'd1 << POS_BITS) - 64'd1);
    localparam int unsigned COUNT_LIMIT  = 32'hFFFF;
    localparam int          TOTAL_ITEMS  = 470;
    localparam int          SETTLE_CYCLES = 16;
    // Far above a run where every beat yields three tokens under the heaviest stalls.
    localparam int          CYCLE_LIMIT  = 100_000;

    // Idling profiles for the sender and the receiver.
    typedef enum logic [1:0] {
        PHASE_NONE,
        PHASE_SENDER,
        PHASE_RECEIVER,
        PHASE_BOTH
    } idle_phase_e;

    // One source beat waiting to be driven, with the idling it runs under.
    typedef struct {
        src_beat_t   beat;
        int unsigned gap_pct;
        int unsigned stall_pct;
        bit          drain_first;   // hold until every expected token is back
    } src_item_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_beat_t src_beat = '0;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    tok_beat_t tok_beat;

    src_item_t   pending_src[$];
    tok_beat_t   expected_tokens[$];
    int unsigned tok_stall_pct = 0;
    int          failures = 0;
    int          cycle_count = 0;

    // Stimulus builder state.
    int unsigned fill_gap_pct;
    int unsigned fill_stall_pct;
    bit          fill_drain;

    // Scanner state of the prediction.
    lex_mode_t   scan_mode;
    int unsigned cur_line;
    int unsigned cur_col;
    int unsigned word_line;
    int unsigned word_col;
    int unsigned word_len;
    int unsigned dot_col;
    kw_prog_t    kw_state;

    dsl_source_tokenizer #(
        .POSITION_BITS (POS_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_beat  (tok_beat)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) || b == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic int unsigned count_add(input int unsigned v, input int unsigned d);
        return (v + d > COUNT_LIMIT) ? COUNT_LIMIT : v + d;
    endfunction

    function automatic int unsigned pos_next(input int unsigned v);
        return (v < POS_LIMIT) ? v + 1 : POS_LIMIT;
    endfunction

    // Output fields are 16 bits wide whatever the position width.
    function automatic logic [15:0] to_field(input int unsigned v);
        return (v > 32'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic queue_token(input logic [3:0] kind, input int unsigned ln,
                               input int unsigned cl, input int unsigned len,
                               input logic closing);
        tok_beat_t t;
        t.token_kind   = kind;
        t.start_line   = to_field(ln);
        t.start_column = to_field(cl);
        t.token_length = to_field(len);
        t.last_token   = closing;
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    // Emit the identifier, keyword or number being collected.
    task automatic close_word();
        logic [3:0] kind;
        kind = KIND_NUMBER;
        if (scan_mode == MODE_IDENT)
            kind = (kw_state == KW_LET) ? KIND_LET :
                   (kw_state == KW_TILE) ? KIND_TILE : KIND_IDENT;
        queue_token(kind, word_line, word_col, word_len, 1'b0);
    endtask

    task automatic open_word(input lex_mode_t m);
        scan_mode = m;
        word_line = cur_line;
        word_col  = cur_col;
        word_len  = 1;
    endtask

    task automatic clear_scanner();
        scan_mode = MODE_IDLE;
        cur_line  = 1;
        cur_col   = 1;
        word_line = 0;
        word_col  = 0;
        word_len  = 0;
        dot_col   = 0;
        kw_state  = KW_NONE;
    endtask

    // Feed one accepted source byte; queues the tokens it completes.
    task automatic scan_source_byte(input logic [7:0] b, input logic last);
        logic       rescan;
        logic       closed;
        logic       is_punct;
        logic [3:0] punct_kind;
        logic [7:0] kw_want;
        rescan     = 1'b0;
        closed     = 1'b0;
        is_punct   = 1'b1;
        punct_kind = KIND_AT;
        kw_want    = 8'h00;

        case (scan_mode)
            MODE_IDLE: rescan = 1'b1;
            MODE_IDENT:
            begin
                if (is_letter(b) || is_digit(b))
                begin
                    word_len = count_add(word_len, 1);
                    // let and tile prefixes advance by one code each
                    case (kw_state)
                        KW_L, KW_TIL: kw_want = CH_LC_E;
                        KW_LE:        kw_want = CH_LC_T;
                        KW_T:         kw_want = CH_LC_I;
                        KW_TI:        kw_want = CH_LC_L;
                        default:      kw_want = 8'h00;
                    endcase
                    kw_state = (kw_want != 8'h00 && b == kw_want) ? kw_state + 3'd1 : KW_NONE;
                end
                else
                begin
                    close_word();
                    rescan = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (is_digit(b))
                    word_len = count_add(word_len, 1);
                else if (b == CH_DOT)
                begin
                    dot_col   = cur_col;
                    scan_mode = MODE_DOTPEND;
                end
                else
                begin
                    close_word();
                    rescan = 1'b1;
                end
            end
            MODE_DOTPEND:
            begin
                if (is_digit(b))
                begin
                    word_len  = count_add(word_len, 2);
                    scan_mode = MODE_FRAC;
                end
                else
                begin
                    // number without its dot, then the dot itself is bad
                    close_word();
                    queue_token(KIND_ERROR, cur_line, dot_col, 1, 1'b1);
                    scan_mode = MODE_DROP;
                end
            end
            MODE_FRAC:
            begin
                if (is_digit(b))
                    word_len = count_add(word_len, 1);
                else
                begin
                    close_word();
                    rescan = 1'b1;
                end
            end
            MODE_LEADDOT:
            begin
                if (is_digit(b))
                begin
                    word_len  = 2;
                    scan_mode = MODE_FRAC;
                end
                else
                begin
                    queue_token(KIND_ERROR, word_line, word_col, 1, 1'b1);
                    scan_mode = MODE_DROP;
                end
            end
            default: ;  // dropping until the last byte
        endcase

        if (rescan)
        begin
            scan_mode = MODE_IDLE;
            case (b)
                CH_LPAREN: punct_kind = KIND_LPAREN;
                CH_RPAREN: punct_kind = KIND_RPAREN;
                CH_COMMA:  punct_kind = KIND_COMMA;
                CH_PLUS:   punct_kind = KIND_PLUS;
                CH_STAR:   punct_kind = KIND_STAR;
                CH_MINUS:  punct_kind = KIND_MINUS;
                CH_EQUALS: punct_kind = KIND_EQUALS;
                CH_AT:     punct_kind = KIND_AT;
                default:   is_punct = 1'b0;
            endcase
            if (is_punct)
                queue_token(punct_kind, cur_line, cur_col, 1, 1'b0);
            else if (is_letter(b))
            begin
                open_word(MODE_IDENT);
                kw_state = (b == CH_LC_L) ? KW_L : (b == CH_LC_T) ? KW_T : KW_NONE;
            end
            else if (is_digit(b))
                open_word(MODE_INT);
            else if (b == CH_DOT)
                open_word(MODE_LEADDOT);
            else if (b != CH_SPACE && b != CH_CR && b != CH_TAB && b != CH_LF)
            begin
                queue_token(KIND_ERROR, cur_line, cur_col, 1, 1'b1);
                scan_mode = MODE_DROP;
            end
        end

        if (b == CH_LF)
        begin
            cur_line = pos_next(cur_line);
            cur_col  = 1;
        end
        else
            cur_col = pos_next(cur_col);

        if (last)
        begin
            case (scan_mode)
                MODE_IDENT, MODE_INT, MODE_FRAC: close_word();
                MODE_DOTPEND:
                begin
                    close_word();
                    queue_token(KIND_ERROR, cur_line, dot_col, 1, 1'b1);
                    closed = 1'b1;
                end
                MODE_LEADDOT:
                begin
                    queue_token(KIND_ERROR, word_line, word_col, 1, 1'b1);
                    closed = 1'b1;
                end
                MODE_DROP: closed = 1'b1;
                default: ;
            endcase
            // an error already closed the source: no END after it
            if (!closed)
                queue_token(KIND_END, cur_line, cur_col, 0, 1'b1);
            clear_scanner();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_letter();
        int unsigned r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LC_A + 8'(r);
        if (r < 52)
            return CH_UC_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 7))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_COMMA;
            3:       return CH_PLUS;
            4:       return CH_STAR;
            5:       return CH_MINUS;
            6:       return CH_EQUALS;
            default: return CH_AT;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last);
        src_item_t it;
        it.beat.source_byte = b;
        it.beat.is_last     = last;
        it.gap_pct          = fill_gap_pct;
        it.stall_pct        = fill_stall_pct;
        it.drain_first      = fill_drain;
        fill_drain = 1'b0;
        pending_src.insert(pending_src.size(), it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    // New idling profile; its first beat waits for the token queue to drain.
    task automatic enter_phase(input idle_phase_e ph);
        case (ph)
            PHASE_NONE:
            begin
                fill_gap_pct   = 0;
                fill_stall_pct = 0;
            end
            PHASE_SENDER:
            begin
                fill_gap_pct   = 48;
                fill_stall_pct = 0;
            end
            PHASE_RECEIVER:
            begin
                fill_gap_pct   = 0;
                fill_stall_pct = 48;
            end
            default:
            begin
                fill_gap_pct   = 28;
                fill_stall_pct = 28;
            end
        endcase
        fill_drain = 1'b1;
    endtask

    // Mostly well-formed token runs; some sources carry a bad byte or a
    // dangling dot somewhere in the middle.
    task automatic add_random_source();
        int n_parts;
        int noise_at;
        int n;
        n_parts  = $urandom_range(1, 8);
        noise_at = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, n_parts - 1)) : -1;
        for (int p = 0; p < n_parts; p++)
        begin
            if (p == noise_at)
            begin
                if ($urandom_range(0, 1))
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                else
                begin
                    add_byte(rand_digit(), 1'b0);
                    add_byte(CH_DOT, 1'b0);
                    add_byte(rand_punct(), 1'b0);
                end
            end
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        case ($urandom_range(0, 5))
                            0:       add_text("let");
                            1:       add_text("tile");
                            2:       add_text("le");
                            3:       add_text("til");
                            4:       add_text("tiles");
                            default: add_text("let_1");
                        endcase
                    end
                    else
                    begin
                        add_byte(rand_letter(), 1'b0);
                        n = $urandom_range(0, 5);
                        repeat (n)
                            add_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter(),
                                     1'b0);
                    end
                end
                2:
                begin
                    n = $urandom_range(0, 4);   // zero digits gives the leading-dot form
                    repeat (n)
                        add_byte(rand_digit(), 1'b0);
                    if (n == 0 || $urandom_range(0, 1))
                    begin
                        add_byte(CH_DOT, 1'b0);
                        n = $urandom_range(1, 3);
                        repeat (n)
                            add_byte(rand_digit(), 1'b0);
                    end
                end
                3, 4:    add_byte(rand_punct(), 1'b0);
                default: add_byte(rand_blank(), 1'b0);
            endcase
            if ($urandom_range(0, 1))
                add_byte(rand_blank(), 1'b0);
        end
        // closing byte flushes whatever is pending
        case ($urandom_range(0, 5))
            0:       add_byte(rand_letter(), 1'b1);
            1:       add_byte(rand_digit(), 1'b1);
            2:       add_byte(rand_punct(), 1'b1);
            3:       add_byte(rand_blank(), 1'b1);
            4:       add_byte(CH_DOT, 1'b1);
            default: add_byte(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Source beat driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        src_item_t nxt;
        if (!rst_n)
        begin
            src_valid     <= 1'b0;
            src_beat      <= '0;
            tok_stall_pct <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                scan_source_byte(src_beat.source_byte, src_beat.is_last);
            // a stalled beat stays put; otherwise pick the next or idle
            if (!(src_valid && src_stall))
            begin
                if (pending_src.size() != 0
                    && !(pending_src[0].drain_first && expected_tokens.size() != 0)
                    && $urandom_range(0, 99) >= pending_src[0].gap_pct)
                begin
                    nxt = pending_src.pop_front();
                    src_beat      <= nxt.beat;
                    src_valid     <= 1'b1;
                    tok_stall_pct <= nxt.stall_pct;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token beat monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tok_beat_t want;
        if (!rst_n)
            tok_stall <= 1'b0;
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token beat: kind %0d line %0d column %0d",
                           tok_beat.token_kind, tok_beat.start_line, tok_beat.start_column);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 16'(want.token_kind), 16'(tok_beat.token_kind));
                    check_field("start_line", want.start_line, tok_beat.start_line);
                    check_field("start_column", want.start_column, tok_beat.start_column);
                    check_field("token_length", want.token_length, tok_beat.token_length);
                    check_field("last_token", 16'(want.last_token), 16'(tok_beat.last_token));
                end
            end
            tok_stall <= ($urandom_range(0, 99) < tok_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dsl_source_tokenizer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sources, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int src_count;

        clear_scanner();
        enter_phase(PHASE_NONE);

        // every punctuator, both keywords, fraction and leading-dot numbers
        add_text("let\ttile=(.5,3.2)*-x@");
        add_byte(CH_PLUS, 1'b1);
        // dot without digit after a number, on a line break
        add_text("7.");
        add_byte(CH_LF, 1'b1);
        // unknown bytes at both ends of the range; the second is dropped
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // lone dot, and number with dot held on the last byte
        add_byte(CH_DOT, 1'b1);
        add_byte(rand_digit(), 1'b0);
        add_byte(CH_DOT, 1'b1);
        // whitespace only, then an identifier flushed by the last byte
        add_byte(CH_SPACE, 1'b1);
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte(CH_UC_Z, 1'b1);

        // random sources, rotating the idling profile every few sources
        src_count = 0;
        while (pending_src.size() < TOTAL_ITEMS)
        begin
            if (src_count % 6 == 0)
                enter_phase(idle_phase_e'((src_count / 6) % 4));
            add_random_source();
            src_count++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_src.size() != 0 || src_valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("dsl_source_tokenizer verification clean");
        else
            $display("dsl_source_tokenizer verification failed");
        $finish;
    end

endmodule

// ----- dsl_source_tokenizer.f -----
rtl/dst_pkg.sv
rtl/dsl_source_tokenizer.sv
test/tb.sv
